// File: sv/mbgs_pkg.sv
// Shared types and constants for the masked bilinear grid sampler.
// No dependencies; every other file depends on this package.
package mbgs_pkg;
	localparam int CELLS = 64;
	localparam int GRID  = CELLS + 1;
	localparam int DEPTH = GRID * GRID;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(CELLS + 1);
	localparam int VW    = 24;
	localparam int QW    = 17;
	localparam int WW    = 33;
	localparam int NUMW  = 58;
	localparam int DNW   = 57;
	localparam int DDW   = 34;
	localparam logic [QW-1:0] ONE_Q16 = 17'h10000;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef enum logic [1:0] {
		SRC_INTERP  = 2'd0,
		SRC_NEAREST = 2'd1,
		SRC_NONE    = 2'd2
	} src_t;

	typedef struct packed {
		logic [VW-1:0] value;
		logic          valid;
	} cell_t;
endpackage

// File: sv/mbgs_if.sv
// Request and response channel interfaces for the grid sampler.
// Depends on mbgs_pkg for field widths.
interface mbgs_req_if;
	logic                     valid;
	logic                     ready;
	logic                     kind;
	logic [6:0]               grid_row;
	logic [6:0]               grid_col;
	logic signed [mbgs_pkg::VW-1:0] sample_value;
	logic                     sample_valid;
	logic [mbgs_pkg::QW-1:0]  u_coord;
	logic [mbgs_pkg::QW-1:0]  v_coord;

	modport source (output valid, kind, grid_row, grid_col, sample_value, sample_valid,
		u_coord, v_coord, input ready);
	modport sink (input valid, kind, grid_row, grid_col, sample_value, sample_valid,
		u_coord, v_coord, output ready);
endinterface

interface mbgs_rsp_if;
	logic                           valid;
	logic                           ready;
	logic signed [mbgs_pkg::VW-1:0] result_elevation;
	logic [1:0]                     result_source;

	modport source (output valid, result_elevation, result_source, input ready);
	modport sink (input valid, result_elevation, result_source, output ready);
endinterface

// File: sv/mbgs_div.sv
// Restoring divider, one quotient bit per cycle, for the rounded mean.
// Depends on mbgs_pkg for operand widths.
module mbgs_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [mbgs_pkg::DNW-1:0]   dividend,
	input  logic [mbgs_pkg::DDW-1:0]   divisor,
	output logic                       done,
	output logic [mbgs_pkg::VW-1:0]    quo
);
	import mbgs_pkg::*;

	localparam int CNTW = $clog2(VW + 1);

	logic [DNW-1:0]  rem_q;
	logic [DNW-1:0]  dsh_q;
	logic [VW-1:0]   quo_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic            ge;

	assign ge = rem_q >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(VW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dsh_q <= DNW'(divisor) << (VW - 1);
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge) rem_q <= rem_q - dsh_q;
			quo_q <= {quo_q[VW-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule

// File: sv/masked_bilinear_grid_sampler_core.sv
// Top level of the masked bilinear grid sampler: grid memory, sequencer, output word.
// Depends on mbgs_pkg, mbgs_if and mbgs_div.
//
// A write word stores one sample and the block is ready again at once. A query runs from its
// accept through four corner reads, each a read state and an accumulate state, through the
// single memory read port, a state to start the divider, the bit-serial divider plus a step
// to take its quotient, and a step to hand over the result. A result that waits on the output
// register holds the block until it is taken. When every weighted corner is a hole the block
// walks square rings around the rounded position, a read state and a check state per probed
// sample, out to ring CELLS on a grid without valid samples. The grid has no reset; every
// sample must be written before a query reads it.
module masked_bilinear_grid_sampler_core (
	input  logic clk,
	input  logic arst_n,
	mbgs_req_if.sink   req,
	mbgs_rsp_if.source rsp
);
	import mbgs_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_WRD  = 8'b0000_0010,
		ST_ACC  = 8'b0000_0100,
		ST_DST  = 8'b0000_1000,
		ST_DIV  = 8'b0001_0000,
		ST_RRD  = 8'b0010_0000,
		ST_RCHK = 8'b0100_0000,
		ST_FIN  = 8'b1000_0000
	} state_t;

	typedef enum logic [2:0] {
		PH_CTR = 3'b001,
		PH_TB  = 3'b010,
		PH_LR  = 3'b100
	} phase_t;

	localparam int SXW = QW + CW;

	state_t state_q;
	phase_t phase_q;

	cell_t           mem [DEPTH];
	cell_t           rdata_q;
	logic [AW-1:0]   raddr;

	logic [CW-1:0]   x0_q, x1_q, y0_q, y1_q, r0_q, c0_q;
	logic [15:0]     tx_q, ty_q;
	logic [1:0]      k_q;
	logic [WW-1:0]   w_q;
	logic signed [NUMW-1:0] num_q;
	logic [WW-1:0]   den_q;
	logic            neg_q;
	logic [CW-1:0]   ring_q, j_q;
	logic            side_q;
	logic signed [VW-1:0] res_q;
	src_t            src_q;
	logic signed [VW-1:0] out_val_q;
	logic [1:0]      out_src_q;
	logic            out_valid_q;

	// query setup
	logic [QW-1:0]   u_sat, v_sat;
	logic [SXW-1:0]  sx, sy;
	logic [SXW:0]    sxr, syr;
	logic [CW-1:0]   x0_n, y0_n, rr_n, cr_n;

	assign u_sat = (req.u_coord > ONE_Q16) ? ONE_Q16 : req.u_coord;
	assign v_sat = (req.v_coord > ONE_Q16) ? ONE_Q16 : req.v_coord;
	assign sx    = SXW'(u_sat) * SXW'(CELLS);
	assign sy    = SXW'(v_sat) * SXW'(CELLS);
	assign sxr   = (SXW+1)'(sx) + (SXW+1)'(17'h08000);
	assign syr   = (SXW+1)'(sy) + (SXW+1)'(17'h08000);

	always_comb begin
		x0_n = (sx[SXW-1:16] > (SXW-16)'(CELLS)) ? CW'(CELLS) : CW'(sx[SXW-1:16]);
		y0_n = (sy[SXW-1:16] > (SXW-16)'(CELLS)) ? CW'(CELLS) : CW'(sy[SXW-1:16]);
		cr_n = (sxr[SXW:16] > (SXW-15)'(CELLS)) ? CW'(CELLS) : CW'(sxr[SXW:16]);
		rr_n = (syr[SXW:16] > (SXW-15)'(CELLS)) ? CW'(CELLS) : CW'(syr[SXW:16]);
	end

	// ring bounds
	logic [CW:0]   rsum, csum, lr_end;
	logic [CW-1:0] rlo, rhi, clo, chi;
	logic [CW-1:0] prow, pcol;

	always_comb begin
		rsum = {1'b0, r0_q} + {1'b0, ring_q};
		csum = {1'b0, c0_q} + {1'b0, ring_q};
		rlo  = (r0_q > ring_q) ? r0_q - ring_q : '0;
		clo  = (c0_q > ring_q) ? c0_q - ring_q : '0;
		rhi  = (rsum > (CW+1)'(CELLS)) ? CW'(CELLS) : rsum[CW-1:0];
		chi  = (csum > (CW+1)'(CELLS)) ? CW'(CELLS) : csum[CW-1:0];
		lr_end = {1'b0, rlo} + {1'b0, j_q} + (CW+1)'(2);
		unique case (phase_q)
			PH_CTR: begin
				prow = r0_q;
				pcol = c0_q;
			end
			PH_TB: begin
				prow = side_q ? rhi : rlo;
				pcol = clo + j_q;
			end
			PH_LR: begin
				prow = rlo + j_q + CW'(1);
				pcol = side_q ? chi : clo;
			end
			default: begin
				prow = r0_q;
				pcol = c0_q;
			end
		endcase
	end

	// read address
	logic [CW-1:0] crow, ccol;
	assign crow = k_q[1] ? y1_q : y0_q;
	assign ccol = k_q[0] ? x1_q : x0_q;

	always_comb begin
		if (state_q == ST_RRD)
			raddr = AW'(prow) * AW'(GRID) + AW'(pcol);
		else
			raddr = AW'(crow) * AW'(GRID) + AW'(ccol);
	end

	logic          wr_en;
	logic [AW-1:0] waddr;
	assign wr_en = req.valid && req.ready && (req.kind == KIND_WRITE)
		&& (req.grid_row <= 7'(CELLS)) && (req.grid_col <= 7'(CELLS));
	assign waddr = AW'(req.grid_row) * AW'(GRID) + AW'(req.grid_col);

	always_ff @(posedge clk) begin
		if (wr_en) mem[waddr] <= '{value: req.sample_value, valid: req.sample_valid};
		rdata_q <= mem[raddr];
	end

	// weights and accumulation
	logic [QW-1:0]          fa, fb;
	logic signed [NUMW-1:0] prod;
	logic [WW-1:0]          den_sum;
	assign fa      = k_q[0] ? QW'(tx_q) : ONE_Q16 - QW'(tx_q);
	assign fb      = k_q[1] ? QW'(ty_q) : ONE_Q16 - QW'(ty_q);
	assign prod    = NUMW'($signed(rdata_q.value) * $signed({1'b0, w_q}));
	assign den_sum = rdata_q.valid ? den_q + w_q : den_q;

	// divider operands
	logic [DNW-2:0]  mag;
	logic [DNW-1:0]  dvd;
	logic            div_done;
	logic [VW-1:0]   quo;
	assign mag = num_q[NUMW-1] ? (DNW-1)'(-num_q) : (DNW-1)'(num_q);
	assign dvd = {mag, 1'b0} + DNW'(den_q);

	mbgs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == ST_DST),
		.dividend (dvd),
		.divisor  ({den_q, 1'b0}),
		.done     (div_done),
		.quo      (quo)
	);

	logic out_free;
	assign out_free = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_CTR;
			out_valid_q <= 1'b0;
			k_q         <= '0;
			ring_q      <= '0;
			j_q         <= '0;
			side_q      <= 1'b0;
		end else begin
			// load a new word or drop the taken one
			out_valid_q <= (state_q == ST_FIN && out_free) || (out_valid_q && !rsp.ready);
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid && req.kind == KIND_QUERY) begin
						k_q     <= '0;
						state_q <= ST_WRD;
					end
				end
				ST_WRD: state_q <= ST_ACC;
				ST_ACC: begin
					k_q <= k_q + 1'b1;
					if (k_q != 2'd3)
						state_q <= ST_WRD;
					else if (den_sum != '0)
						state_q <= ST_DST;
					else begin
						phase_q <= PH_CTR;
						ring_q  <= '0;
						j_q     <= '0;
						side_q  <= 1'b0;
						state_q <= ST_RRD;
					end
				end
				ST_DST: state_q <= ST_DIV;
				ST_DIV: if (div_done) state_q <= ST_FIN;
				ST_RRD: state_q <= ST_RCHK;
				ST_RCHK: begin
					if (rdata_q.valid) begin
						state_q <= ST_FIN;
					end else begin
						priority if (phase_q == PH_CTR) begin
							state_q <= ST_RRD;
							ring_q  <= CW'(1);
							phase_q <= PH_TB;
							j_q     <= '0;
						end else if (!side_q) begin
							state_q <= ST_RRD;
							side_q  <= 1'b1;
						end else begin
							side_q <= 1'b0;
							priority if (phase_q == PH_TB && clo + j_q != chi) begin
								state_q <= ST_RRD;
								j_q     <= j_q + 1'b1;
							end else if (phase_q == PH_TB && rlo + CW'(1) != rhi) begin
								state_q <= ST_RRD;
								phase_q <= PH_LR;
								j_q     <= '0;
							end else if (phase_q == PH_LR && lr_end != {1'b0, rhi}) begin
								state_q <= ST_RRD;
								j_q     <= j_q + 1'b1;
							end else if (ring_q == CW'(CELLS)) begin
								state_q <= ST_FIN;
							end else begin
								// advance to next ring
								state_q <= ST_RRD;
								ring_q  <= ring_q + 1'b1;
								phase_q <= PH_TB;
								j_q     <= '0;
							end
						end
					end
				end
				ST_FIN: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				x0_q  <= x0_n;
				y0_q  <= y0_n;
				x1_q  <= (x0_n == CW'(CELLS)) ? x0_n : x0_n + 1'b1;
				y1_q  <= (y0_n == CW'(CELLS)) ? y0_n : y0_n + 1'b1;
				tx_q  <= sx[15:0];
				ty_q  <= sy[15:0];
				c0_q  <= cr_n;
				r0_q  <= rr_n;
				num_q <= '0;
				den_q <= '0;
			end
			ST_WRD: w_q <= WW'(fa * fb);
			ST_ACC: begin
				if (rdata_q.valid) num_q <= num_q + prod;
				den_q <= den_sum;
			end
			ST_DST: neg_q <= num_q[NUMW-1];
			ST_DIV: begin
				res_q <= neg_q ? -$signed(quo) : $signed(quo);
				src_q <= SRC_INTERP;
			end
			ST_RCHK: begin
				res_q <= rdata_q.valid ? rdata_q.value : '0;
				src_q <= rdata_q.valid ? SRC_NEAREST : SRC_NONE;
			end
			ST_FIN: begin
				if (out_free) begin
					out_val_q <= res_q;
					out_src_q <= src_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid            = out_valid_q;
	assign rsp.result_elevation = out_val_q;
	assign rsp.result_source    = out_src_q;

`ifndef SYNTHESIS
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready && req.kind == KIND_QUERY |=> !req.ready)
		else $error("ready held high after query");
	a_div_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside divide wait");
	a_none_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN && src_q == SRC_NONE |-> res_q == '0)
		else $error("no-sample result not zero");
	a_ring_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ring_q <= CW'(CELLS))
		else $error("ring counter past grid");
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_FIN)
		else $error("result word raised outside finish");
`endif
endmodule
